// ----- hdl/rgb_led_strip_serializer_macros.svh -----
// Assertion macros used by the checker file of the LED strip serializer.
`ifndef RGB_LED_STRIP_SERIALIZER_MACROS_SVH
`define RGB_LED_STRIP_SERIALIZER_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define RLS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that also holds while reset is high.
`define RLS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rls_pkg.sv -----
// Package with the transaction types, codes and helpers of the LED strip serializer.
`default_nettype none

package rls_pkg;

   localparam int DefaultMaxPixels = 256;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [1:0] CMD_IDLE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_SHOW  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_LED_COUNT       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS_CODE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW_TICKS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH_TICKS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW_TICKS  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATCH_TICKS     = 3'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  pixel_index;
      logic [23:0] color_rgb;
   } req_item_type;

   typedef struct packed {
      logic        line_level;
      logic        busy_res;
      logic [23:0] read_rgb;
      logic        read_valid;
      logic        rejected;
   } rsp_item_type;

   // A code of zero leaves the channel as it is.
   function automatic logic [7:0] scale_chan(input logic [7:0] chan, input logic [7:0] code);
      logic [15:0] prod;
      prod = {8'd0, chan} * {8'd0, code};
      return (code == 8'd0) ? chan : prod[15:8];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/rgb_led_strip_serializer.sv -----
// Single-wire RGB LED strip serializer with pixel store, read-back and timed bit pulses.
// Every input transaction is one tick of line timing and gives exactly one response
// transaction: one transaction per clock cycle is sustained while the response side does
// not stall and no clear runs; a response passes the input register, then the response
// register. The tick logic sits between the input register and the response register;
// the pixel store is a memory with one write port, one read port for pixel reads and one
// read port for the bit being sent. After reset the block clears the pixel store, one
// entry per cycle, holding req_stall high meanwhile; configuration writes are still taken.
`default_nettype none

module rgb_led_strip_serializer #(
   parameter int MAX_PIXELS = rls_pkg::DefaultMaxPixels
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire rls_pkg::req_item_type           req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output rls_pkg::rsp_item_type                rsp_payload,
   input  wire logic                            csr_write,
   input  wire logic [rls_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rls_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rls_pkg::*;

   localparam int AW      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int EFF_MAX = (MAX_PIXELS < 511) ? MAX_PIXELS : 511;
   localparam int CNTW    = $clog2(EFF_MAX + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;
   localparam logic [1:0] PH_LOW  = 2'd3;

   logic [8:0]  led_count_ff;
   logic [7:0]  brightness_ff;
   logic [9:0]  one_high_ff;
   logic [9:0]  one_low_ff;
   logic [9:0]  zero_high_ff;
   logic [9:0]  zero_low_ff;
   logic [15:0] latch_ff;

   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   logic          s1_valid_ff;
   req_item_type  s1_item_ff;
   logic [23:0]   rd_mem_ff;
   logic          byp_hit_ff;
   logic [23:0]   byp_data_ff;
   logic [23:0]   pix_word_ff;

   logic [1:0]      phase_ff, phase_in;
   logic [CNTW-1:0] send_pixel_ff, send_pixel_in;
   logic [4:0]      send_bit_ff, send_bit_in;
   logic [9:0]      pulse_ff, pulse_in;
   logic [15:0]     gap_ff, gap_in;

   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic [23:0]   mem [MAX_PIXELS];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [23:0]   mem_wdata;
   logic [AW-1:0] send_addr;

   logic            out_free, s1_move, req_take;
   logic [CNTW-1:0] eff_cnt;
   logic            rejected, idx_ok, wr_fire, read_valid, cur_bit;
   logic [23:0]     wr_data, rd_word;
   logic [1:0]      phase_cmd;
   logic [9:0]      pulse_inc, high_lim, low_lim;
   logic [4:0]      bit_inc;
   logic [CNTW-1:0] pix_next;
   logic [4:0]      bit_next;
   logic [15:0]     gap_sat;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = clr_active_ff || (s1_valid_ff && !out_free);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   always_comb begin
      if (led_count_ff < MAX_PIXELS) begin
         eff_cnt = CNTW'(led_count_ff);
      end else begin
         eff_cnt = CNTW'(MAX_PIXELS);
      end
   end

   always_comb begin
      rejected   = (s1_item_ff.command != CMD_IDLE) && (phase_ff != PH_IDLE);
      idx_ok     = s1_item_ff.pixel_index < eff_cnt;
      wr_fire    = s1_move && !rejected && (s1_item_ff.command == CMD_WRITE) && idx_ok;
      wr_data    = {scale_chan(s1_item_ff.color_rgb[15:8], brightness_ff),
                    scale_chan(s1_item_ff.color_rgb[23:16], brightness_ff),
                    scale_chan(s1_item_ff.color_rgb[7:0], brightness_ff)};
      rd_word    = byp_hit_ff ? byp_data_ff : rd_mem_ff;
      read_valid = !rejected && (s1_item_ff.command == CMD_READ);
      phase_cmd  = (!rejected && (s1_item_ff.command == CMD_SHOW)) ? PH_WAIT : phase_ff;

      cur_bit   = pix_word_ff[5'd23 - send_bit_ff];
      pulse_inc = pulse_ff + 10'd1;
      high_lim  = cur_bit ? one_high_ff : zero_high_ff;
      low_lim   = cur_bit ? one_low_ff : zero_low_ff;
      bit_inc   = send_bit_ff + 5'd1;
      gap_sat   = (gap_ff != 16'hFFFF) ? gap_ff + 16'd1 : gap_ff;

      if (bit_inc >= 5'd24) begin
         bit_next = 5'd0;
         pix_next = send_pixel_ff + CNTW'(1);
      end else begin
         bit_next = bit_inc;
         pix_next = send_pixel_ff;
      end

      phase_in      = phase_cmd;
      send_pixel_in = send_pixel_ff;
      send_bit_in   = send_bit_ff;
      pulse_in      = pulse_ff;
      gap_in        = gap_ff;

      case (phase_cmd)
         PH_IDLE: begin
            gap_in = gap_sat;
         end
         PH_WAIT: begin
            if (gap_ff >= latch_ff) begin
               send_pixel_in = '0;
               send_bit_in   = 5'd0;
               pulse_in      = 10'd0;
               if (eff_cnt == '0) begin
                  phase_in = PH_IDLE;
                  gap_in   = 16'd0;
               end else begin
                  phase_in = PH_HIGH;
               end
            end else begin
               gap_in = gap_sat;
            end
         end
         PH_HIGH: begin
            pulse_in = pulse_inc;
            if (pulse_inc >= high_lim || pulse_inc == 10'd0) begin
               phase_in = PH_LOW;
               pulse_in = 10'd0;
            end
         end
         PH_LOW: begin
            pulse_in = pulse_inc;
            if (pulse_inc >= low_lim || pulse_inc == 10'd0) begin
               pulse_in = 10'd0;
               if (pix_next >= eff_cnt) begin
                  phase_in      = PH_IDLE;
                  send_pixel_in = '0;
                  send_bit_in   = 5'd0;
                  gap_in        = 16'd0;
               end else begin
                  phase_in      = PH_HIGH;
                  send_pixel_in = pix_next;
                  send_bit_in   = bit_next;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_item_in.line_level = (phase_cmd == PH_HIGH);
      rsp_item_in.busy_res   = (phase_cmd != PH_IDLE);
      rsp_item_in.read_valid = read_valid;
      rsp_item_in.rejected   = rejected;
      if (read_valid && idx_ok) begin
         rsp_item_in.read_rgb = {rd_word[15:8], rd_word[23:16], rd_word[7:0]};
      end else begin
         rsp_item_in.read_rgb = 24'd0;
      end
   end

   assign mem_we    = clr_active_ff || wr_fire;
   assign mem_waddr = clr_active_ff ? clr_addr_ff : AW'(s1_item_ff.pixel_index);
   assign mem_wdata = clr_active_ff ? 24'd0 : wr_data;
   assign send_addr = s1_move ? AW'(send_pixel_in) : AW'(send_pixel_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (req_take) begin
         rd_mem_ff <= mem[AW'(req_payload.pixel_index)];
      end
      pix_word_ff <= mem[send_addr];
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff  <= req_payload;
         byp_hit_ff  <= wr_fire &&
                        (AW'(s1_item_ff.pixel_index) == AW'(req_payload.pixel_index));
         byp_data_ff <= wr_data;
      end
      if (s1_move) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff   <= 9'd12;
         brightness_ff  <= 8'd0;
         one_high_ff    <= 10'd70;
         one_low_ff     <= 10'd60;
         zero_high_ff   <= 10'd35;
         zero_low_ff    <= 10'd80;
         latch_ff       <= 16'd5000;
         clr_active_ff  <= 1'b1;
         clr_addr_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         send_pixel_ff  <= '0;
         send_bit_ff    <= 5'd0;
         pulse_ff       <= 10'd0;
         gap_ff         <= 16'hFFFF;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LED_COUNT:       led_count_ff   <= csr_data[8:0];
               CSR_BRIGHTNESS_CODE: brightness_ff  <= csr_data[7:0];
               CSR_ONE_HIGH_TICKS:  one_high_ff    <= csr_data[9:0];
               CSR_ONE_LOW_TICKS:   one_low_ff     <= csr_data[9:0];
               CSR_ZERO_HIGH_TICKS: zero_high_ff   <= csr_data[9:0];
               CSR_ZERO_LOW_TICKS:  zero_low_ff    <= csr_data[9:0];
               CSR_LATCH_TICKS:     latch_ff       <= csr_data;
               default: begin
               end
            endcase
         end
         if (clr_active_ff) begin
            if (clr_addr_ff == LAST_ADDR) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
            end
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= s1_move || (rsp_valid_ff && rsp_stall);
         if (s1_move) begin
            phase_ff      <= phase_in;
            send_pixel_ff <= send_pixel_in;
            send_bit_ff   <= send_bit_in;
            pulse_ff      <= pulse_in;
            gap_ff        <= gap_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rls_checker.sv -----
// Port-level checker of the LED strip serializer and its bind to the top level.
`default_nettype none

`include "rgb_led_strip_serializer_macros.svh"

module rls_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rls_pkg::rsp_item_type rsp_payload
);

   // Reset empties the pipeline and starts the store clear, which holds off requests.
   `RLS_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_valid && req_stall, "reset left traffic")

   `RLS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled response changed")

   // Every accepted transaction has a response waiting once it has passed the input register.
   `RLS_ASSERT(a_req_to_rsp, clock, reset, req_valid && !req_stall |-> ##2 rsp_valid, "accepted transaction gave no response")

   // A read is only answered while the line is idle.
   `RLS_ASSERT(a_read_idle, clock, reset, rsp_valid && rsp_payload.read_valid |-> !rsp_payload.busy_res && !rsp_payload.rejected && !rsp_payload.line_level, "read answered while busy")

endmodule

bind rgb_led_strip_serializer rls_checker u_rls_checker (.*);

`default_nettype wire
